// ===== design/mpba_pkg.sv =====
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared types, constants and helpers for the multi-page bump allocator.
// ----------------------------------------------------------------------------
package mpba_pkg;

    // Page geometry
    localparam int MAX_PAGES    = 8;
    localparam int BUFFER_BYTES = 32 * 1024 * 1024;
    localparam int PAGE_W       = $clog2(MAX_PAGES);
    localparam int CNT_W        = $clog2(MAX_PAGES + 1);
    localparam int OFS_W        = 26;

    // Field widths
    localparam int REQ_W   = 17;
    localparam int PAD_W   = 18;
    localparam int ALIGN_W = 4;
    localparam int MDS_W   = 17;
    localparam int PIDX_W  = 3;
    localparam int ROFS_W  = 25;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_SZ = 1'd1;

    // Register reset values
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd8;
    localparam logic [MDS_W-1:0]   MDS_RESET   = 17'h10000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_RESET = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_LARGE    = 2'd1,
        ST_OUT_OF_PAGES = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_PAD,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

    // One result transaction
    typedef struct packed {
        status_t             status;
        logic [PIDX_W-1:0]   page;
        logic [ROFS_W-1:0]   offset;
        logic                opened;
    } result_t;

    // Controller to offset store
    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        logic [OFS_W-1:0]  wr_data;
        logic              clr_all;
    } mem_req_t;

    // Round a request up to the alignment
    function automatic logic [PAD_W-1:0] pad_size(input logic [REQ_W-1:0] req,
                                                  input logic [ALIGN_W-1:0] align);
        logic [PAD_W-1:0] mask;
        mask = (PAD_W'(1) << align) - PAD_W'(1);
        return (PAD_W'(req) + mask) & ~mask;
    endfunction

    // A page qualifies when at least max_data_size bytes remain
    function automatic logic page_fits(input logic [OFS_W-1:0] off,
                                       input logic [MDS_W-1:0] mds);
        logic [OFS_W-1:0] buf_bytes;
        logic [OFS_W-1:0] room;
        buf_bytes = OFS_W'(BUFFER_BYTES);
        room      = buf_bytes - off;
        return (off <= buf_bytes) && (room >= OFS_W'(mds));
    endfunction

endpackage

// ===== design/mpba_offset_store.sv =====
// ----------------------------------------------------------------------------
// mpba_offset_store
// Per-page offset memory with registered read and per-entry
// valid bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module mpba_offset_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mpba_pkg::mem_req_t         mem_req,
    output logic [mpba_pkg::OFS_W-1:0] rd_data
);
    import mpba_pkg::*;

    logic [OFS_W-1:0]     mem [MAX_PAGES];
    logic [MAX_PAGES-1:0] valid_reg;
    logic [OFS_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;

    // Storage and registered read
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    // Valid bits: reset and the reset request clear all entries at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (mem_req.clr_all) begin
                valid_reg <= '0;
            end else if (mem_req.wr_en) begin
                valid_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en) begin
                rd_valid_reg <= valid_reg[mem_req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== design/mpba_alloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpba_alloc_ctrl
// Request sequencer: pads the size, scans open pages first-fit through the
// offset store, writes back the new offset and holds the result register.
// ----------------------------------------------------------------------------
module mpba_alloc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [mpba_pkg::REQ_W-1:0]   s_request_bytes,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mpba_pkg::result_t            m_result,
    input  logic [mpba_pkg::ALIGN_W-1:0] align_log2,
    input  logic [mpba_pkg::MDS_W-1:0]   max_data_size,
    output mpba_pkg::mem_req_t           mem_req,
    input  logic [mpba_pkg::OFS_W-1:0]   rd_data
);
    import mpba_pkg::*;

    fsm_state_t        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [PAD_W-1:0]  padded_reg, padded_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [PAGE_W-1:0] chk_idx_reg, chk_idx_next;
    logic              chk_pend_reg, chk_pend_next;
    logic [CNT_W-1:0]  pages_reg, pages_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [PAD_W-1:0]  padded_c;

    assign padded_c = pad_size(req_reg, align_log2);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
            chk_pend_reg  <= 1'b0;
            rd_idx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            out_valid_reg <= out_valid_next;
            chk_pend_reg  <= chk_pend_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        req_reg     <= req_next;
        padded_reg  <= padded_next;
        chk_idx_reg <= chk_idx_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // Next state and outputs
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        padded_next    = padded_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_pend_next  = chk_pend_reg;
        pages_next     = pages_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_req        = '0;
        s_ready        = 1'b0;

        // Output register drains independently of the sequencer
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = op_t'(s_op);
                    req_next   = s_request_bytes;
                    state_next = FSM_PAD;
                end
            end

            FSM_PAD: begin
                padded_next   = padded_c;
                rd_idx_next   = '0;
                chk_pend_next = 1'b0;
                if (op_reg == OP_RESET) begin
                    mem_req.clr_all = 1'b1;
                    res_next   = '{status: ST_OK, page: '0, offset: '0, opened: 1'b0};
                    state_next = FSM_DONE;
                end else if (padded_c > PAD_W'(max_data_size)) begin
                    res_next   = '{status: ST_TOO_LARGE, page: '0, offset: '0, opened: 1'b0};
                    state_next = FSM_DONE;
                end else begin
                    state_next = FSM_SCAN;
                end
            end

            FSM_SCAN: begin
                if (chk_pend_reg && page_fits(rd_data, max_data_size)) begin
                    // First fit: bump this page
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = chk_idx_reg;
                    mem_req.wr_data = rd_data + OFS_W'(padded_reg);
                    res_next   = '{status: ST_OK, page: PIDX_W'(chk_idx_reg),
                                   offset: rd_data[ROFS_W-1:0], opened: 1'b0};
                    state_next = FSM_DONE;
                end else if (rd_idx_reg < pages_reg) begin
                    // Issue the next page read, checked next cycle
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_idx_reg[PAGE_W-1:0];
                    chk_idx_next    = rd_idx_reg[PAGE_W-1:0];
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    chk_pend_next   = 1'b1;
                end else if (chk_pend_reg) begin
                    chk_pend_next = 1'b0;
                end else if (pages_reg >= CNT_W'(MAX_PAGES)) begin
                    res_next   = '{status: ST_OUT_OF_PAGES, page: '0, offset: '0,
                                   opened: 1'b0};
                    state_next = FSM_DONE;
                end else begin
                    // Open the next page
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pages_reg[PAGE_W-1:0];
                    mem_req.wr_data = OFS_W'(padded_reg);
                    pages_next = pages_reg + CNT_W'(1);
                    res_next   = '{status: ST_OK, page: PIDX_W'(pages_reg[PAGE_W-1:0]),
                                   offset: '0, opened: 1'b1};
                    state_next = FSM_DONE;
                end
            end

            FSM_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== design/multi_page_bump_allocator_core.sv =====
// Sequence: an accepted request is padded, then a reset request or a too_large
// answer goes straight to the result register; otherwise the first-fit scan reads
// the offset memory of each open page in turn and bumps the first that fits, else
// opens a new page or answers out_of_pages; m_ready stalls hold the result back.
// A new request is accepted only after the previous result is registered.
// Reset: synchronous active-low aresetn closes all pages and restores settings.
// ----------------------------------------------------------------------------
// multi_page_bump_allocator_core
// Top level: configuration registers, request sequencer and offset store.
// ----------------------------------------------------------------------------
module multi_page_bump_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [mpba_pkg::REQ_W-1:0]     s_request_bytes,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [mpba_pkg::PIDX_W-1:0]    m_page_index,
    output logic [mpba_pkg::ROFS_W-1:0]    m_region_offset,
    output logic                           m_opened_page,
    input  logic                           cfg_we,
    input  logic [mpba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpba_pkg::CFG_W-1:0]     cfg_wdata
);
    import mpba_pkg::*;

    logic [ALIGN_W-1:0] align_reg;
    logic [MDS_W-1:0]   mds_reg;
    mem_req_t           mem_req;
    logic [OFS_W-1:0]   rd_data;
    result_t            result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= ALIGN_RESET;
            mds_reg   <= MDS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ALIGN_LOG2:  align_reg <= cfg_wdata[ALIGN_W-1:0];
                CFG_MAX_DATA_SZ: mds_reg   <= cfg_wdata[MDS_W-1:0];
                default: ;
            endcase
        end
    end

    mpba_alloc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_request_bytes (s_request_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (result),
        .align_log2      (align_reg),
        .max_data_size   (mds_reg),
        .mem_req         (mem_req),
        .rd_data         (rd_data)
    );

    mpba_offset_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign m_status        = result.status;
    assign m_page_index    = result.page;
    assign m_region_offset = result.offset;
    assign m_opened_page   = result.opened;

endmodule

// ===== design/mpba_checker.sv =====
// ----------------------------------------------------------------------------
// mpba_checker
// Port-level checks on the result channel of the allocator core.
// ----------------------------------------------------------------------------
module mpba_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_status,
    input logic [mpba_pkg::PIDX_W-1:0]    m_page_index,
    input logic [mpba_pkg::ROFS_W-1:0]    m_region_offset,
    input logic                           m_opened_page
);
    import mpba_pkg::*;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_page_index) && $stable(m_region_offset)
            && $stable(m_opened_page))
        else $error("result changed while stalled");

    // Failed requests carry no grant
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_page_index == '0)
            && (m_region_offset == '0) && !m_opened_page)
        else $error("failed request carries a grant");

    // A newly opened page starts at offset zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_opened_page |-> (m_status == ST_OK) && (m_region_offset == '0))
        else $error("opened page with nonzero offset");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multi_page_bump_allocator_core mpba_checker u_mpba_checker (.*);
